// ===== hdl/fspc_pkg.sv =====
package fspc_pkg;

	localparam int unsigned CountClockHz   = 108000000;
	localparam int unsigned CounterModulus = 65536;

	localparam logic [1:0] REQ_OVERFLOW = 2'd0;
	localparam logic [1:0] REQ_CAPTURE  = 2'd1;
	localparam logic [1:0] REQ_TICK     = 2'd2;

	localparam logic [2:0] REG_TARGET = 3'd0;
	localparam logic [2:0] REG_KP     = 3'd1;
	localparam logic [2:0] REG_KI     = 3'd2;
	localparam logic [2:0] REG_DMIN   = 3'd3;
	localparam logic [2:0] REG_DMAX   = 3'd4;
	localparam logic [2:0] REG_PPR    = 3'd5;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [15:0] capture_value;
	} in_word_t;

	typedef struct packed {
		logic [15:0] drive_value;
		logic [6:0]  duty_percent;
		logic [15:0] speed_rpm;
		logic        clamped;
	} out_word_t;

	// request and reply between sequencer and divider
	typedef struct packed {
		logic        start;
		logic [63:0] num;
		logic [63:0] den;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] quo;
	} div_rsp_t;

endpackage

// ===== hdl/fspc_div.sv =====
module fspc_div (
	input  logic              clk,
	input  logic              arst_n,
	input  fspc_pkg::div_req_t req,
	output fspc_pkg::div_rsp_t rsp
);
	import fspc_pkg::*;

	logic [63:0] rem_q;
	logic [63:0] quo_q;
	logic [63:0] den_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [64:0] trial;

	assign trial = {rem_q, quo_q[63]} - {1'b0, den_q};

	// restoring divide, one quotient bit a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd64;
				rem_q  <= '0;
				quo_q  <= req.num;
				den_q  <= req.den;
			end else if (busy_q) begin
				if (!trial[64]) begin
					rem_q <= trial[63:0];
					quo_q <= {quo_q[62:0], 1'b1};
				end else begin
					rem_q <= {rem_q[62:0], quo_q[63]};
					quo_q <= {quo_q[62:0], 1'b0};
				end
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
endmodule

// ===== hdl/fan_speed_pi_controller.sv =====
// Fan speed PI controller.
// Input channel (in_valid/in_stall/in_data) carries events: timer overflow,
// tach capture with a 16-bit count, or control tick. Output channel
// (out_valid/out_stall/out_data) carries one word per control tick: drive
// value, duty percent, speed used and clamp flag.
// An overflow or unused event is handled in the idle state. A capture runs
// one 64-step serial divide for the speed, or none for a zero or negative
// period or zero pulses per rev. A tick runs a 16x17 and a 16x32 product,
// then a 64-step divide for the duty; the next event is taken only after
// the word is registered. in_stall is high while an event is in work.
// The configuration port (cfg_we/cfg_index/cfg_data) writes a register
// while cfg_we is high; write only while idle.
// Reset clears the tach and integral state and loads register defaults.
// When the receiver stalls, the result word is held in the output register
// and in_stall stays high until the word is taken.
module fan_speed_pi_controller #(
	parameter int unsigned COUNT_CLOCK_HZ  = fspc_pkg::CountClockHz,
	parameter int unsigned COUNTER_MODULUS = fspc_pkg::CounterModulus
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  fspc_pkg::in_word_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output fspc_pkg::out_word_t out_data,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [15:0]         cfg_data
);
	import fspc_pkg::*;

	localparam logic [63:0] SpeedNum = 64'(COUNT_CLOCK_HZ) * 64'd60;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_SDIV = 7'b0000010,
		ST_SWT  = 7'b0000100,
		ST_MP   = 7'b0001000,
		ST_MI   = 7'b0010000,
		ST_CLMP = 7'b0100000,
		ST_DWT  = 7'b1000000
	} state_t;

	state_t state_q;
	logic [15:0] target_q, kp_q, ki_q, dmin_q, dmax_q;
	logic [7:0]  ppr_q;
	logic [15:0] ovf_q, last_q, rpm_q;
	logic signed [31:0] esum_q;
	logic signed [16:0] err_q;
	logic signed [49:0] acc_q;
	logic [15:0] drive_q;
	logic        hit_q;
	logic        zero_q;
	div_req_t    dreq;
	div_rsp_t    drsp;
	out_word_t   out_q;
	logic        ovalid_q;

	// period and input-side values
	logic signed [33:0] steps;
	logic signed [33:0] esum_ext;
	logic signed [31:0] esum_sat;
	logic signed [49:0] prod;
	logic signed [49:0] mag;
	logic signed [49:0] qdrv;
	logic               hit_lo, hit_hi;
	logic signed [33:0] back_ext;
	logic [63:0]        sq;

	assign steps = 34'(ovf_q) * 34'(COUNTER_MODULUS)
		+ 34'($signed({1'b0, in_data.capture_value})) - 34'($signed({1'b0, last_q}));
	assign esum_ext = 34'(esum_q) + 34'(err_q);
	assign esum_sat = (esum_ext > 34'sh07FFFFFFF) ? 32'sh7FFFFFFF :
		(esum_ext < -34'sh080000000) ? 32'sh80000000 : esum_ext[31:0];
	// shared multiplier
	assign prod = (state_q == ST_MP)
		? 50'($signed({1'b0, kp_q})) * 50'(err_q)
		: 50'($signed({1'b0, ki_q})) * 50'(esum_q);
	assign mag  = acc_q[49] ? -acc_q : acc_q;
	assign qdrv = acc_q[49] ? -(mag >>> 16) : (mag >>> 16);
	assign hit_lo = qdrv < 50'($signed({1'b0, dmin_q}));
	assign hit_hi = qdrv > 50'($signed({1'b0, dmax_q}));
	assign back_ext = 34'(esum_q) - 34'(err_q);
	assign sq = drsp.quo;

	assign in_stall = (state_q != ST_IDLE) || (ovalid_q && out_stall);

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= 16'd5100;
			kp_q     <= 16'd3277;
			ki_q     <= 16'd655;
			dmin_q   <= 16'd0;
			dmax_q   <= 16'd5100;
			ppr_q    <= 8'd7;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TARGET: target_q <= cfg_data;
				REG_KP:     kp_q     <= cfg_data;
				REG_KI:     ki_q     <= cfg_data;
				REG_DMIN:   dmin_q   <= cfg_data;
				REG_DMAX:   dmax_q   <= cfg_data;
				REG_PPR:    ppr_q    <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ovf_q    <= '0;
			last_q   <= '0;
			rpm_q    <= '0;
			esum_q   <= '0;
			ovalid_q <= 1'b0;
			dreq     <= '0;
		end else begin
			dreq.start <= 1'b0;
			if (ovalid_q && !out_stall) ovalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid && !in_stall) begin
						case (in_data.req_type)
							REQ_OVERFLOW: if (ovf_q != 16'hFFFF) ovf_q <= ovf_q + 16'd1;
							REQ_CAPTURE: begin
								last_q  <= in_data.capture_value;
								ovf_q   <= '0;
								if (steps <= 0 || ppr_q == 8'd0) begin
									rpm_q <= 16'hFFFF;
								end else begin
									dreq.start <= 1'b1;
									dreq.num   <= SpeedNum;
									dreq.den   <= 64'(ppr_q) * 64'(steps[32:0]);
									state_q    <= ST_SDIV;
								end
							end
							REQ_TICK: begin
								err_q   <= 17'($signed({1'b0, target_q}))
									- 17'($signed({1'b0, rpm_q}));
								state_q <= ST_MP;
							end
							default: ;
						endcase
					end
				end
				ST_SDIV: state_q <= ST_SWT;
				ST_SWT: if (drsp.done) begin
					rpm_q   <= (sq > 64'd65535) ? 16'hFFFF : sq[15:0];
					state_q <= ST_IDLE;
				end
				ST_MP: begin
					esum_q  <= esum_sat;
					acc_q   <= prod;
					state_q <= ST_MI;
				end
				ST_MI: begin
					acc_q   <= acc_q + prod;
					state_q <= ST_CLMP;
				end
				ST_CLMP: begin
					hit_q <= hit_lo || hit_hi;
					if (hit_lo) drive_q <= dmin_q;
					else if (hit_hi) drive_q <= dmax_q;
					else drive_q <= qdrv[15:0];
					if (hit_lo || hit_hi) begin
						esum_q <= (back_ext > 34'sh07FFFFFFF) ? 32'sh7FFFFFFF :
							(back_ext < -34'sh080000000) ? 32'sh80000000 : back_ext[31:0];
					end
					zero_q     <= (dmax_q == 16'd0);
					dreq.start <= 1'b1;
					dreq.num   <= 64'(hit_lo ? dmin_q : hit_hi ? dmax_q : qdrv[15:0])
						* 64'd100;
					dreq.den   <= 64'(dmax_q);
					state_q    <= ST_DWT;
				end
				ST_DWT: if (drsp.done) begin
					out_q.drive_value  <= drive_q;
					out_q.duty_percent <= zero_q ? 7'd0 :
						(sq > 64'd100) ? 7'd100 : sq[6:0];
					out_q.speed_rpm    <= rpm_q;
					out_q.clamped      <= hit_q;
					ovalid_q           <= 1'b1;
					state_q            <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	fspc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	assign out_valid = ovalid_q;
	assign out_data  = out_q;
endmodule
